// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the vector clamp checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, switched off while reset is low.
`define VMC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define VMC_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/vmc_pkg.sv =====
// ----------------------------------------------------------------------------
// vmc_pkg
// Types and constants shared by the vector magnitude clamp modules.
// ----------------------------------------------------------------------------
`default_nettype none
package vmc_pkg;

    localparam int NUM_LANES   = 4;
    localparam int SQRT_STAGES = 32;
    // Input register plus one register per root bit.
    localparam int SQRT_LAT    = SQRT_STAGES + 1;
    localparam int DIV_STAGES  = 32;
    // Product register, one register per quotient bit, output register.
    localparam int LANE_LAT    = DIV_STAGES + 2;
    // Input, squares, root, compare, lanes, output.
    localparam int PIPE_LAT    = 1 + 1 + SQRT_LAT + 1 + LANE_LAT + 1;

    typedef struct packed {
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
        logic signed [31:0] in_w;
        logic [30:0]        limit;
    } t_req;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
        logic [31:0]        length;
        logic               was_clamped;
    } t_rsp;

    // Data that rides alongside the square root.
    typedef struct packed {
        logic [NUM_LANES-1:0][31:0] mag;
        logic [NUM_LANES-1:0]       neg;
        logic [30:0]                lim;
    } t_side;

    // Everything one scaling lane needs for one component.
    typedef struct packed {
        logic [31:0] mag;
        logic        neg;
        logic [30:0] lim;
        logic [31:0] len;
        logic        clamp;
    } t_lane_in;

endpackage
`default_nettype wire

// ===== hdl/vector_magnitude_clamp_top.sv =====
// Requests pass input, square, root, compare, lane and merge registers in turn.
// Throughput: one request per cycle; busy is never raised, every stage is a
// plain pipeline register and the root and the four dividers are fully staged.
// The receiver cannot stall, so results leave on o_valid without handshake.
// Reset is synchronous and active low; it clears only the valid bits.
// ----------------------------------------------------------------------------
// vector_magnitude_clamp_top
// Caps the x,y,z length of a Q16.16 vector, scaling all four components.
// ----------------------------------------------------------------------------
`default_nettype none
module vector_magnitude_clamp_top (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire vmc_pkg::t_req i_req,
    output logic          o_busy,
    output logic          o_valid,
    output vmc_pkg::t_rsp o_result
);
    import vmc_pkg::*;

    // The pipeline never backs up, so a request is taken whenever start is high.
    assign o_busy = 1'b0;

    logic        w_acc;
    logic [NUM_LANES-1:0][31:0] w_raw;

    // Input stage: split each component into magnitude and sign.
    logic        r_s0_vld;
    t_side       r_s0;

    // Square stage: exact squares of x, y and z.
    logic        r_s1_vld;
    t_side       r_s1;
    logic [63:0] r_sq [0:2];
    logic [63:0] w_sum;

    // Root and compare stage.
    logic        w_rt_vld;
    logic [31:0] w_rt;
    t_side       w_rt_side;
    logic        r_c_vld;
    t_side       r_c;
    logic [31:0] r_c_len;
    logic        r_c_clp;

    // Length and flag travel beside the lanes.
    logic [31:0] r_len_dly [0:LANE_LAT-1];
    logic        r_clp_dly [0:LANE_LAT-1];

    logic [NUM_LANES-1:0]       w_ln_vld;
    logic [NUM_LANES-1:0][31:0] w_ln_val;

    logic        r_out_vld;
    t_rsp        r_out;

    assign w_acc = i_start && !o_busy;
    assign w_raw = {i_req.in_x, i_req.in_y, i_req.in_z, i_req.in_w};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else begin
            r_s0_vld <= w_acc;
        end
        // Lane 3 is x, lane 0 is w. The most negative value maps to 2^31,
        // which the 32-bit unsigned magnitude holds exactly.
        for (int i = 0; i < NUM_LANES; i++) begin
            r_s0.neg[i] <= w_raw[i][31];
            r_s0.mag[i] <= w_raw[i][31] ? (32'd0 - w_raw[i]) : w_raw[i];
        end
        r_s0.lim <= i_req.limit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= r_s0_vld;
        end
        r_s1     <= r_s0;
        r_sq[0]  <= 64'(r_s0.mag[3]) * 64'(r_s0.mag[3]);
        r_sq[1]  <= 64'(r_s0.mag[2]) * 64'(r_s0.mag[2]);
        r_sq[2]  <= 64'(r_s0.mag[1]) * 64'(r_s0.mag[1]);
    end

    // The sum of three squares is at most 3*2^62 and never wraps.
    assign w_sum = r_sq[0] + r_sq[1] + r_sq[2];

    vmc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_vld),
        .i_val   (w_sum),
        .i_side  (r_s1),
        .o_valid (w_rt_vld),
        .o_root  (w_rt),
        .o_side  (w_rt_side)
    );

    // A length truncated onto the limit does not clamp; a zero length never does.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= w_rt_vld;
        end
        r_c     <= w_rt_side;
        r_c_len <= w_rt;
        r_c_clp <= (w_rt > {1'b0, w_rt_side.lim});
    end

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        t_lane_in w_in;

        assign w_in.mag   = r_c.mag[l];
        assign w_in.neg   = r_c.neg[l];
        assign w_in.lim   = r_c.lim;
        assign w_in.len   = r_c_len;
        assign w_in.clamp = r_c_clp;

        vmc_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_c_vld),
            .i_in    (w_in),
            .o_valid (w_ln_vld[l]),
            .o_value (w_ln_val[l])
        );
    end

    always_ff @(posedge i_clk) begin
        r_len_dly[0] <= r_c_len;
        r_clp_dly[0] <= r_c_clp;
        for (int i = 1; i < LANE_LAT; i++) begin
            r_len_dly[i] <= r_len_dly[i-1];
            r_clp_dly[i] <= r_clp_dly[i-1];
        end
    end

    // Merge stage: gather the four lanes with the length and the flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= &w_ln_vld;
        end
        r_out.out_x       <= w_ln_val[3];
        r_out.out_y       <= w_ln_val[2];
        r_out.out_z       <= w_ln_val[1];
        r_out.out_w       <= w_ln_val[0];
        r_out.length      <= r_len_dly[LANE_LAT-1];
        r_out.was_clamped <= r_clp_dly[LANE_LAT-1];
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

endmodule
`default_nettype wire

// ===== hdl/vmc_sqrt.sv =====
// ----------------------------------------------------------------------------
// vmc_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module vmc_sqrt (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [63:0]   i_val,
    input  wire vmc_pkg::t_side i_side,
    output logic               o_valid,
    output logic [31:0]        o_root,
    output vmc_pkg::t_side     o_side
);
    import vmc_pkg::*;

    logic        r_vld  [0:SQRT_STAGES];
    logic [35:0] r_rem  [0:SQRT_STAGES];
    logic [31:0] r_root [0:SQRT_STAGES];
    logic [63:0] r_val  [0:SQRT_STAGES];
    t_side       r_side [0:SQRT_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_val[0]  <= i_val;
        r_side[0] <= i_side;
    end

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        logic [35:0] w_sh;
        logic [35:0] w_tr;
        logic        w_ge;

        // Bring down the next two radicand bits and try root*4+1.
        assign w_sh = {r_rem[k][33:0], r_val[k][63:62]};
        assign w_tr = {2'b00, r_root[k], 2'b01};
        assign w_ge = (w_sh >= w_tr);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_rem[k+1]  <= w_ge ? (w_sh - w_tr) : w_sh;
            r_root[k+1] <= {r_root[k][30:0], w_ge};
            r_val[k+1]  <= {r_val[k][61:0], 2'b00};
            r_side[k+1] <= r_side[k];
        end
    end

    assign o_valid = r_vld[SQRT_STAGES];
    assign o_root  = r_root[SQRT_STAGES];
    assign o_side  = r_side[SQRT_STAGES];

endmodule
`default_nettype wire

// ===== hdl/vmc_lane.sv =====
// ----------------------------------------------------------------------------
// vmc_lane
// One scaling lane: magnitude times limit, divided by length when clamping, sign restored.
// ----------------------------------------------------------------------------
`default_nettype none
module vmc_lane (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire vmc_pkg::t_lane_in i_in,
    output logic               o_valid,
    output logic [31:0]        o_value
);
    import vmc_pkg::*;

    logic [62:0] w_prod;

    logic        r_vld [0:DIV_STAGES];
    logic [31:0] r_rem [0:DIV_STAGES];
    logic [31:0] r_low [0:DIV_STAGES];
    logic [31:0] r_q   [0:DIV_STAGES];
    logic [31:0] r_d   [0:DIV_STAGES];
    logic [31:0] r_mag [0:DIV_STAGES];
    logic        r_neg [0:DIV_STAGES];
    logic        r_clp [0:DIV_STAGES];
    logic        r_out_vld;
    logic [31:0] r_out;
    logic [31:0] w_m;

    assign w_prod = 63'(i_in.mag) * 63'(i_in.lim);

    // When clamping, the quotient is below 2^32, so the upper product bits
    // are already smaller than the divisor and start the remainder.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_rem[0] <= {1'b0, w_prod[62:32]};
        r_low[0] <= w_prod[31:0];
        r_q[0]   <= '0;
        r_d[0]   <= i_in.len;
        r_mag[0] <= i_in.mag;
        r_neg[0] <= i_in.neg;
        r_clp[0] <= i_in.clamp;
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [32:0] w_sh;
        logic        w_ge;

        assign w_sh = {r_rem[k], r_low[k][31]};
        assign w_ge = (w_sh >= {1'b0, r_d[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_rem[k+1] <= w_ge ? 32'(w_sh - {1'b0, r_d[k]}) : w_sh[31:0];
            r_low[k+1] <= {r_low[k][30:0], 1'b0};
            r_q[k+1]   <= {r_q[k][30:0], w_ge};
            r_d[k+1]   <= r_d[k];
            r_mag[k+1] <= r_mag[k];
            r_neg[k+1] <= r_neg[k];
            r_clp[k+1] <= r_clp[k];
        end
    end

    assign w_m = r_clp[DIV_STAGES] ? r_q[DIV_STAGES] : r_mag[DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[DIV_STAGES];
        end
        r_out <= r_neg[DIV_STAGES] ? (32'd0 - w_m) : w_m;
    end

    assign o_valid = r_out_vld;
    assign o_value = r_out;

endmodule
`default_nettype wire

// ===== hdl/vmc_checker.sv =====
// ----------------------------------------------------------------------------
// vmc_checker
// Port-level timing and result checks for the vector magnitude clamp.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module vmc_checker (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire logic     o_busy,
    input  wire logic     o_valid,
    input  wire vmc_pkg::t_rsp o_result
);
    import vmc_pkg::*;

    logic w_zero_len;

    assign w_zero_len = (o_result.length == 32'd0);

    // Every accepted request yields exactly one result after the fixed latency.
    `VMC_ASSERT(a_req_to_rsp, (i_start && !o_busy) |-> ##PIPE_LAT o_valid, "result missing")
    `VMC_ASSERT(a_no_ghost, !(i_start && !o_busy) |-> ##PIPE_LAT !o_valid, "result invented")
    // Clamping implies a length above some limit, so never a zero length.
    `VMC_NEVER(a_clamp_len, o_valid && o_result.was_clamped && w_zero_len, "zero length clamped")
    `VMC_NEVER(a_busy, o_busy, "busy raised")

endmodule

bind vector_magnitude_clamp_top vmc_checker u_vmc_checker (.*);
`default_nettype wire

// ===== tb/vector_magnitude_clamp_checker.sv =====
// ----------------------------------------------------------------------------
// vector_magnitude_clamp_checker
// Watches the request and result channels of the vector clamp, predicts each
// result from the accepted request and compares the two field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module vector_magnitude_clamp_checker (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire logic     i_busy,
    input  wire vmc_pkg::t_req i_req,
    input  wire logic     i_valid,
    input  wire vmc_pkg::t_rsp i_result,
    output int            o_fail_count,
    output int            o_pending,
    output int            o_clamped_count
);
    import vmc_pkg::*;

    t_rsp expected_q[$];

    function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if ({32'd0, trial} * {32'd0, trial} <= v) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic t_rsp clamp_vector(input t_req r);
        t_rsp        p;
        logic [31:0] comp [4];
        logic [32:0] mag;
        logic [63:0] sum;
        logic [63:0] scaled;
        logic        clamp;
        comp[0] = r.in_x;
        comp[1] = r.in_y;
        comp[2] = r.in_z;
        comp[3] = r.in_w;
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            mag = comp[i][31] ? 33'h1_0000_0000 - {1'b0, comp[i]} : {1'b0, comp[i]};
            sum += {31'd0, mag} * {31'd0, mag};
        end
        p.length = floor_sqrt(sum);
        clamp = p.length > {1'b0, r.limit};
        p.was_clamped = clamp;
        for (int i = 0; i < 4; i++) begin
            mag = comp[i][31] ? 33'h1_0000_0000 - {1'b0, comp[i]} : {1'b0, comp[i]};
            scaled = {31'd0, mag};
            if (clamp) begin
                scaled = (scaled * {33'd0, r.limit}) / {32'd0, p.length};
            end
            comp[i] = comp[i][31] ? 32'(-scaled) : scaled[31:0];
        end
        p.out_x = comp[0];
        p.out_y = comp[1];
        p.out_z = comp[2];
        p.out_w = comp[3];
        return p;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s: got %h, expected %h", what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count    = 0;
        o_clamped_count = 0;
        o_pending       = 0;
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && i_start && !i_busy) begin
            expected_q.push_back(clamp_vector(i_req));
        end
        if (i_rst_n && i_valid) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", i_result.length, '0);
            end else begin
                want = expected_q.pop_front();
                if (want.was_clamped) o_clamped_count++;
                if (i_result.out_x !== want.out_x)
                    report_mismatch("out_x", i_result.out_x, want.out_x);
                if (i_result.out_y !== want.out_y)
                    report_mismatch("out_y", i_result.out_y, want.out_y);
                if (i_result.out_z !== want.out_z)
                    report_mismatch("out_z", i_result.out_z, want.out_z);
                if (i_result.out_w !== want.out_w)
                    report_mismatch("out_w", i_result.out_w, want.out_w);
                if (i_result.length !== want.length)
                    report_mismatch("length", i_result.length, want.length);
                if (i_result.was_clamped !== want.was_clamped)
                    report_mismatch("was_clamped", 32'(i_result.was_clamped),
                                    32'(want.was_clamped));
            end
        end
        o_pending = expected_q.size();
    end
endmodule
`default_nettype wire

// ===== tb/vector_magnitude_clamp_top_tb.sv =====
// ----------------------------------------------------------------------------
// vector_magnitude_clamp_top_tb
// Drives directed and random vectors into the magnitude clamp with random
// gaps between requests; a separate checker predicts and compares results.
// ----------------------------------------------------------------------------
`default_nettype none
module vector_magnitude_clamp_top_tb;
    import vmc_pkg::*;

    // Watchdog limit on consecutive cycles with no request accepted and no result. The
    // longest sender gap plus the pipeline latency is well under it.
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 900;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    t_req i_req = '0;
    logic o_busy;
    logic o_valid;
    t_rsp o_result;

    int fail_count;
    int pending;
    int clamped_count;
    int idle_cycles = 0;
    int directed_count = 0;

    always #2 i_clk = ~i_clk;

    vector_magnitude_clamp_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_req    (i_req),
        .o_busy   (o_busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    vector_magnitude_clamp_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_busy          (o_busy),
        .i_req           (i_req),
        .i_valid         (o_valid),
        .i_result        (o_result),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_clamped_count (clamped_count)
    );

    // The watchdog counts cycles in which no request and no result moved.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Mostly no gap or a short one; now and then a long pause, so that the
    // pipeline drains completely between some requests.
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 120);
    endfunction

    // Components come from several ranges: full random words, extremes and
    // small values, so that both clamped and unclamped vectors are common.
    function automatic logic [31:0] random_component();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            3: return 32'($signed($urandom_range(0, 2 * 65536 * 4)) - 65536 * 4);
            4: return 32'($signed($urandom_range(0, 2 * 65536 * 200)) - 65536 * 200);
            default: return 32'($signed($urandom_range(0, 32)) - 16);
        endcase
    endfunction

    function automatic logic [30:0] random_limit();
        case ($urandom_range(0, 4))
            0: return 31'($urandom());
            1: return 31'd65536;
            2: return 31'($urandom_range(0, 65536 * 8));
            3: return $urandom_range(0, 1) ? 31'h7fff_ffff : 31'd0;
            default: return 31'($urandom_range(0, 65536 * 300));
        endcase
    endfunction

    // Presents one request, holds it until accepted, then drops start only if
    // a gap follows, so start never gets two assignments in one time step.
    task automatic send_request(input t_req r);
        int gap;
        i_start <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        gap = gap_length();
        if (gap > 0) begin
            i_start <= 1'b0;
            i_req   <= '0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_vector(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z, input logic [31:0] w,
                               input logic [30:0] lim);
        t_req r;
        r.in_x  = x;
        r.in_y  = y;
        r.in_z  = z;
        r.in_w  = w;
        r.limit = lim;
        send_request(r);
        directed_count++;
    endtask

    initial begin
        t_req r;
        int drain;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A zero vector is never clamped, whatever the limit.
        send_vector(0, 0, 0, 32'h1234_5678, 0);
        send_vector(0, 0, 0, 32'h8000_0000, 31'h7fff_ffff);
        // A zero limit clamps every nonzero vector to zero, w too.
        send_vector(32'h0001_0000, 0, 0, 32'h7fff_ffff, 0);
        send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        // The most negative component in every lane with the largest limit.
        send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    31'h7fff_ffff);
        send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                    31'h7fff_ffff);
        send_vector(32'h8000_0000, 0, 0, 32'h7fff_ffff, 31'h7fff_ffff);
        // A length that truncates onto the limit is not clamped, while one
        // just above the limit is.
        send_vector(32'h0003_0000, 32'h0004_0000, 0, 32'h0009_0000, 31'h0005_0000);
        send_vector(32'h0003_0000, 32'h0004_0000, 0, 32'h0009_0000, 31'h0004_ffff);
        send_vector(32'h0001_0000, 32'h0001_0000, 0, 0, 31'h0001_6a09);
        send_vector(32'h0001_0000, 32'h0001_0000, 0, 0, 31'h0001_6a0a);
        // Normalize: a limit of one caps the length, negative lanes included.
        send_vector(32'hfffd_0000, 32'h0004_0000, 32'hfff0_0000, 32'h8000_0000,
                    31'd65536);
        // Large w takes no part in the length.
        send_vector(1, 1, 1, 32'h7fff_ffff, 31'd1);
        send_vector(32'hffff_ffff, 0, 0, 32'h8000_0000, 0);
        send_vector(0, 0, 32'h0000_0002, 32'h8000_0001, 31'd1);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            r.in_x  = random_component();
            r.in_y  = random_component();
            r.in_z  = random_component();
            r.in_w  = random_component();
            r.limit = random_limit();
            send_request(r);
        end
        i_start <= 1'b0;
        i_req   <= '0;

        // Wait for the last results, then let the clock run on past the pipeline depth.
        drain = 0;
        while (pending != 0 && drain < 10 * PIPE_LAT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (2 * PIPE_LAT) @(posedge i_clk);

        $display("Sent %0d directed and %0d random vectors; %0d results were clamped.",
                 directed_count, RANDOM_ITEMS, clamped_count);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", fail_count, pending);
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
